// ----- hdl/rbfd_pkg.sv -----
// Package with types and constants for the frame deframer.
package rbfd_pkg;
   localparam int RING_DEPTH = 128;
   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int MAX_FRAME = 64;
   localparam int LENGTH_OFFSET = 5;
   localparam int COMMAND_OFFSET = 9;
   localparam int MIN_UNREAD = 9;
   localparam int SEARCH_TAIL = 3;
   localparam int MIN_FRAME = 11;
   localparam int MIN_NEED = (LENGTH_OFFSET + 4 > MIN_UNREAD) ? LENGTH_OFFSET + 4 : MIN_UNREAD;
   localparam logic [31:0] SYNC_RESET = 32'h59485A53;
   localparam logic OP_STORE = 1'b0;
   localparam logic OP_POLL = 1'b1;
   localparam logic [1:0] REG_SYNC_WORD = 2'd0;

   typedef struct packed {
      logic       opcode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       status;
      logic [7:0] frame_byte;
      logic       last_byte;
      logic [7:0] command;
      logic [6:0] frame_length;
   } rsp_type;

   typedef struct packed {
      logic             rd_en;
      logic [PTR_W-1:0] rd_addr;
   } ring_rd_type;
endpackage

// ----- hdl/rbfd_ring.sv -----
// Byte ring store with one write port and one registered read port.
module rbfd_ring (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [rbfd_pkg::PTR_W-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  rbfd_pkg::ring_rd_type    rd,
   output logic [7:0]               rd_data
);
   import rbfd_pkg::*;
   logic [7:0] mem [RING_DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd.rd_en) begin
         rd_data <= mem[rd.rd_addr];
      end
   end
endmodule

// ----- hdl/ring_buffer_frame_deframer_unit.sv -----
// Top level of the frame deframer: sequencer around a shared byte ring read port.
// A poll reads the ring one byte at a time through the single read port: sync
// search up to 4 reads per position, length 4 reads, checksum length reads, and
// delivery length reads.
// Reset is synchronous and clears the offsets, flags and the sync word to its default.
// Results are strobed for one cycle; the receiver cannot stall them.
module ring_buffer_frame_deframer_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_start,
   output logic                req_busy,
   input  rbfd_pkg::req_type   req_data,
   output logic                rsp_strobe,
   output rbfd_pkg::rsp_type   rsp_data,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [1:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);
   import rbfd_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SYNC  = 7'b0000010,
      S_LEN   = 7'b0000100,
      S_SUM   = 7'b0001000,
      S_CMD   = 7'b0010000,
      S_SEND  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [PTR_W-1:0] rd_off_ff, rd_off_in, wr_off_ff, wr_off_in;
   logic hdr_ff, hdr_in;
   logic [6:0] plen_ff, plen_in;
   logic [31:0] sync_ff, sync_in;
   logic [PTR_W:0] pos_ff, pos_in;
   logic [2:0] bi_ff, bi_in;
   logic [6:0] k_ff, k_in;
   logic [31:0] word_ff, word_in;
   logic [7:0] sum_ff, sum_in, cmd_ff, cmd_in;
   logic pend_ff, pend_in;
   logic strobe_ff, strobe_in;
   rsp_type rsp_ff, rsp_in;
   ring_rd_type rd;
   logic [7:0] rd_data;
   logic wr_en;
   logic [PTR_W:0] unread, need;
   logic [PTR_W-1:0] scan_base;

   rbfd_ring u_ring (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_off_ff), .wr_data(req_data.rx_byte),
      .rd(rd), .rd_data(rd_data)
   );

   assign req_busy = (state_ff != S_IDLE);
   assign wr_en = req_start && !req_busy && req_data.opcode == OP_STORE;
   assign unread = {1'b0, wr_off_ff - rd_off_ff};
   assign need = ({1'b0, 1'b0, plen_ff} > unread) ? '0 : unread;
   assign scan_base = rd_off_ff + pos_ff[PTR_W-1:0];
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_SYNC_WORD) ? sync_ff : 32'd0;
   assign rsp_strobe = strobe_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      state_in = state_ff; rd_off_in = rd_off_ff; wr_off_in = wr_off_ff;
      hdr_in = hdr_ff; plen_in = plen_ff; sync_in = sync_ff;
      pos_in = pos_ff; bi_in = bi_ff; k_in = k_ff; word_in = word_ff;
      sum_in = sum_ff; cmd_in = cmd_ff; pend_in = 1'b0;
      strobe_in = 1'b0; rsp_in = rsp_ff;
      rd.rd_en = 1'b0; rd.rd_addr = rd_off_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_SYNC_WORD) begin
         sync_in = csr_pwdata;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_start) begin
               if (req_data.opcode == OP_STORE) begin
                  wr_off_in = wr_off_ff + 1'b1;
               end else if (need < (PTR_W+1)'(MIN_NEED)) begin
                  state_in = S_DONE;
               end else begin
                  pos_in = '0; bi_in = '0; word_in = '0;
                  state_in = hdr_ff ? (plen_ff == '0 ? S_LEN : S_SUM) : S_SYNC;
                  if (!hdr_ff || plen_ff == '0) begin
                     rd.rd_en = 1'b1;
                     rd.rd_addr = hdr_ff ? rd_off_ff + PTR_W'(LENGTH_OFFSET) : rd_off_ff;
                  end else begin
                     k_in = '0; sum_in = '0; rd.rd_en = 1'b1;
                  end
                  pend_in = 1'b1;
               end
            end
         end
         S_SYNC: begin
            // pend_ff marks that rd_data holds the byte asked for last cycle.
            if (pend_ff) begin
               word_in = {rd_data, word_ff[31:8]};
               bi_in = bi_ff + 1'b1;
               if (bi_ff == 3'd3) begin
                  if ({rd_data, word_ff[31:8]} == sync_ff) begin
                     hdr_in = 1'b1;
                     rd_off_in = scan_base;
                     if (need - pos_ff < (PTR_W+1)'(MIN_NEED)) begin
                        state_in = S_DONE;
                     end else begin
                        state_in = S_LEN; bi_in = '0; pend_in = 1'b1;
                        rd.rd_en = 1'b1; rd.rd_addr = scan_base + PTR_W'(LENGTH_OFFSET);
                     end
                  end else if (pos_ff + (PTR_W+1)'(SEARCH_TAIL + 1) >= need) begin
                     rd_off_in = rd_off_ff + PTR_W'(need - (PTR_W+1)'(SEARCH_TAIL));
                     state_in = S_DONE;
                  end else begin
                     pos_in = pos_ff + 1'b1; bi_in = '0; pend_in = 1'b1;
                     rd.rd_en = 1'b1; rd.rd_addr = scan_base + 1'b1;
                  end
               end else begin
                  pend_in = 1'b1; rd.rd_en = 1'b1;
                  rd.rd_addr = scan_base + PTR_W'(bi_ff + 3'd1);
               end
            end
         end
         S_LEN: begin
            if (pend_ff) begin
               word_in = {rd_data, word_ff[31:8]};
               bi_in = bi_ff + 1'b1;
               if (bi_ff == 3'd3) begin
                  if ({rd_data, word_ff[31:8]} < 32'(MIN_FRAME) ||
                      {rd_data, word_ff[31:8]} > 32'(MAX_FRAME)) begin
                     rd_off_in = rd_off_ff + 1'b1; hdr_in = 1'b0; plen_in = '0;
                     state_in = S_DONE;
                  end else begin
                     plen_in = word_ff[14:8];
                     if (need < {1'b0, word_ff[14:8]}) begin
                        state_in = S_DONE;
                     end else begin
                        state_in = S_SUM; k_in = '0; sum_in = '0; pend_in = 1'b1;
                        rd.rd_en = 1'b1;
                     end
                  end
               end else begin
                  pend_in = 1'b1; rd.rd_en = 1'b1;
                  rd.rd_addr = rd_off_ff + PTR_W'(LENGTH_OFFSET) + PTR_W'(bi_ff + 3'd1);
               end
            end
         end
         S_SUM: begin
            if (pend_ff) begin
               if (k_ff + 7'd1 == plen_ff) begin
                  if (sum_ff != rd_data) begin
                     rd_off_in = rd_off_ff + 1'b1; hdr_in = 1'b0; plen_in = '0;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_CMD; pend_in = 1'b1; rd.rd_en = 1'b1;
                     rd.rd_addr = rd_off_ff + PTR_W'(COMMAND_OFFSET);
                  end
               end else begin
                  sum_in = sum_ff + rd_data; k_in = k_ff + 7'd1;
                  pend_in = 1'b1; rd.rd_en = 1'b1;
                  rd.rd_addr = rd_off_ff + PTR_W'(k_ff + 7'd1);
               end
            end
         end
         S_CMD: begin
            if (pend_ff) begin
               cmd_in = rd_data; k_in = '0; state_in = S_SEND;
               pend_in = 1'b1; rd.rd_en = 1'b1;
            end
         end
         S_SEND: begin
            strobe_in = 1'b1;
            rsp_in.status = 1'b1; rsp_in.frame_byte = rd_data;
            rsp_in.last_byte = (k_ff + 7'd1 == plen_ff);
            rsp_in.command = cmd_ff; rsp_in.frame_length = plen_ff;
            if (k_ff + 7'd1 == plen_ff) begin
               rd_off_in = rd_off_ff + PTR_W'(plen_ff);
               hdr_in = 1'b0; plen_in = '0; state_in = S_IDLE;
            end else begin
               k_in = k_ff + 7'd1; pend_in = 1'b1; rd.rd_en = 1'b1;
               rd.rd_addr = rd_off_ff + PTR_W'(k_ff + 7'd1);
            end
         end
         S_DONE: begin
            strobe_in = 1'b1;
            rsp_in = '{status: 1'b0, frame_byte: 8'd0, last_byte: 1'b1,
                       command: 8'd0, frame_length: 7'd0};
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rd_off_ff <= '0; wr_off_ff <= '0; hdr_ff <= 1'b0;
         plen_ff <= '0; sync_ff <= SYNC_RESET; pend_ff <= 1'b0; strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in; rd_off_ff <= rd_off_in; wr_off_ff <= wr_off_in;
         hdr_ff <= hdr_in; plen_ff <= plen_in; sync_ff <= sync_in;
         pend_ff <= pend_in; strobe_ff <= strobe_in;
      end
      pos_ff <= pos_in; bi_ff <= bi_in; k_ff <= k_in; word_ff <= word_in;
      sum_ff <= sum_in; cmd_ff <= cmd_in; rsp_ff <= rsp_in;
   end

`ifndef SYNTH
   a_store_only_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == S_IDLE) else $error("store while busy");
   a_strobe_from_out: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == S_SEND || $past(state_ff) == S_DONE)
      else $error("stray result strobe");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last_byte |-> !req_busy) else $error("busy after last item");
   a_nf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.status |-> rsp_data.frame_length == 7'd0)
      else $error("no-frame result with length");
`endif
endmodule

// ----- dv/ring_buffer_frame_deframer_unit_tb.sv -----
// Self-checking testbench for the ring buffer frame deframer with its own frame predictor.
module ring_buffer_frame_deframer_unit_tb;
   import rbfd_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   typedef struct {
      logic       op;
      logic [7:0] data;
      bit         no_frame_typed;
   } stim_row_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_start = 1'b0;
   logic            req_busy;
   req_type         req_data = '0;
   logic            rsp_strobe;
   rsp_type         rsp_data;
   logic            csr_psel = 1'b0;
   logic            csr_penable = 1'b0;
   logic            csr_pwrite = 1'b0;
   logic [1:0]      csr_paddr = '0;
   logic [31:0]     csr_pwdata = '0;
   logic [31:0]     csr_prdata;
   logic            csr_pready;

   logic [7:0]      ring_copy [RING_DEPTH];
   int              rd_ofs;
   int              wr_ofs;
   bit              hdr_seen;
   int              pend_len;
   logic [31:0]     sync_copy;
   rsp_type         frame_out_q [$];
   int              errors = 0;
   int              idle_cycles = 0;
   int              items_sent = 0;
   bit              burst = 1'b0;
   logic [7:0]      frame_buf [64];

   localparam rsp_type NO_FRAME = '{status: 1'b0, frame_byte: 8'h00, last_byte: 1'b1,
                                    command: 8'h00, frame_length: 7'd0};

   stim_row_type directed [] = '{
      '{OP_POLL, 8'h00, 1'b1},
      '{OP_STORE, 8'h00, 1'b0}, '{OP_STORE, 8'hFF, 1'b0},
      '{OP_POLL, 8'hFF, 1'b1},
      '{OP_STORE, 8'h53, 1'b0}, '{OP_STORE, 8'h5A, 1'b0}, '{OP_STORE, 8'h48, 1'b0},
      '{OP_STORE, 8'h59, 1'b0}, '{OP_STORE, 8'h00, 1'b0}, '{OP_STORE, 8'h0B, 1'b0},
      '{OP_STORE, 8'h00, 1'b0}, '{OP_STORE, 8'h00, 1'b0}, '{OP_STORE, 8'h00, 1'b0},
      '{OP_STORE, 8'hFF, 1'b0}, '{OP_STORE, 8'h58, 1'b0},
      '{OP_POLL, 8'h00, 1'b0},
      '{OP_STORE, 8'h53, 1'b0}, '{OP_STORE, 8'h5A, 1'b0}, '{OP_STORE, 8'h48, 1'b0},
      '{OP_STORE, 8'h59, 1'b0}, '{OP_STORE, 8'h00, 1'b0}, '{OP_STORE, 8'hFF, 1'b0},
      '{OP_STORE, 8'h00, 1'b0}, '{OP_STORE, 8'h00, 1'b0}, '{OP_STORE, 8'h00, 1'b0},
      '{OP_POLL, 8'h00, 1'b1}
   };

   ring_buffer_frame_deframer_unit i_dut (.*);

   always #5 clock = ~clock;

   function automatic int unread_bytes();
      return (wr_ofs + RING_DEPTH - rd_ofs) % RING_DEPTH;
   endfunction

   function automatic int parse_span();
      int n;
      n = unread_bytes();
      return (pend_len > n) ? 0 : n;
   endfunction

   function automatic logic [7:0] ring_byte(int pos);
      return ring_copy[pos % RING_DEPTH];
   endfunction

   function automatic logic [31:0] ring_word(int pos);
      return {ring_byte(pos + 3), ring_byte(pos + 2), ring_byte(pos + 1), ring_byte(pos)};
   endfunction

   function automatic void drop_one_byte();
      rd_ofs = (rd_ofs + 1) % RING_DEPTH;
      hdr_seen = 1'b0;
      pend_len = 0;
      frame_out_q.push_back(NO_FRAME);
   endfunction

   // Works out the results of one poll and advances the predicted ring state.
   function automatic void deframe_poll();
      int span;
      int pos;
      bit hit;
      logic [31:0] raw;
      logic [7:0] sum;
      logic [7:0] cmd;
      rsp_type r;
      span = parse_span();
      if (span < MIN_NEED) begin
         frame_out_q.push_back(NO_FRAME);
         return;
      end
      if (!hdr_seen) begin
         hit = 1'b0;
         for (pos = 0; pos + SEARCH_TAIL < span; pos++) begin
            if (ring_word(rd_ofs + pos) == sync_copy) begin
               hit = 1'b1;
               break;
            end
         end
         if (!hit) begin
            rd_ofs = (rd_ofs + span - SEARCH_TAIL) % RING_DEPTH;
            frame_out_q.push_back(NO_FRAME);
            return;
         end
         hdr_seen = 1'b1;
         rd_ofs = (rd_ofs + pos) % RING_DEPTH;
         span = parse_span();
         if (span < MIN_NEED) begin
            frame_out_q.push_back(NO_FRAME);
            return;
         end
      end
      if (pend_len == 0) begin
         raw = ring_word(rd_ofs + LENGTH_OFFSET);
         if (raw < MIN_FRAME || raw > MAX_FRAME) begin
            drop_one_byte();
            return;
         end
         pend_len = int'(raw);
         if (span < pend_len) begin
            frame_out_q.push_back(NO_FRAME);
            return;
         end
      end
      sum = 8'h00;
      for (int k = 0; k + 1 < pend_len; k++) sum += ring_byte(rd_ofs + k);
      if (sum != ring_byte(rd_ofs + pend_len - 1)) begin
         drop_one_byte();
         return;
      end
      cmd = ring_byte(rd_ofs + COMMAND_OFFSET);
      for (int k = 0; k < pend_len; k++) begin
         r.status = 1'b1;
         r.frame_byte = ring_byte(rd_ofs + k);
         r.last_byte = (k + 1 == pend_len);
         r.command = cmd;
         r.frame_length = 7'(pend_len);
         frame_out_q.push_back(r);
      end
      rd_ofs = (rd_ofs + pend_len) % RING_DEPTH;
      hdr_seen = 1'b0;
      pend_len = 0;
   endfunction

   function automatic int pick_gap();
      int sel;
      sel = $urandom_range(0, 9);
      if (burst || sel < 6) return (sel < 3) ? 0 : $urandom_range(0, 2);
      if (sel < 9) return $urandom_range(3, 8);
      return $urandom_range(20, 40);
   endfunction

   task automatic send_item(logic op, logic [7:0] data, bit typed);
      int gap;
      int queued;
      gap = pick_gap();
      if (gap > 0) begin
         req_start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_start <= 1'b1;
      req_data <= '{opcode: op, rx_byte: data};
      do @(posedge clock); while (req_busy);
      items_sent++;
      if (op == OP_STORE) begin
         ring_copy[wr_ofs] = data;
         wr_ofs = (wr_ofs + 1) % RING_DEPTH;
      end else begin
         queued = frame_out_q.size();
         deframe_poll();
         if (typed) begin
            while (frame_out_q.size() > queued) void'(frame_out_q.pop_back());
            frame_out_q.push_back(NO_FRAME);
         end
      end
   endtask

   task automatic wait_quiet();
      req_start <= 1'b0;
      @(posedge clock);
      while (frame_out_q.size() != 0 || req_busy) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_sync(logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= REG_SYNC_WORD;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sync_copy = value;
      @(posedge clock);
   endtask

   // Sends one frame, possibly damaged, with noise before it and polls scattered through it.
   task automatic send_frame_run();
      int len;
      int kind;
      logic [31:0] len_field;
      logic [7:0] sum;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, MAX_FRAME) : $urandom_range(11, 20);
      kind = $urandom_range(0, 9);
      len_field = len;
      if (kind == 8) begin
         case ($urandom_range(0, 2))
            0: len_field = $urandom_range(0, MIN_FRAME - 1);
            1: len_field = $urandom_range(MAX_FRAME + 1, 300);
            default: len_field = $urandom;
         endcase
      end
      for (int k = 0; k < 4; k++) frame_buf[k] = sync_copy[8*k +: 8];
      frame_buf[4] = 8'($urandom);
      for (int k = 0; k < 4; k++) frame_buf[LENGTH_OFFSET + k] = len_field[8*k +: 8];
      for (int k = 9; k < len - 1; k++) frame_buf[k] = 8'($urandom);
      sum = 8'h00;
      for (int k = 0; k < len - 1; k++) sum += frame_buf[k];
      frame_buf[len - 1] = (kind == 9) ? sum + 8'($urandom_range(1, 255)) : sum;
      repeat ($urandom_range(0, 4)) send_item(OP_STORE, 8'($urandom), 1'b0);
      for (int k = 0; k < len; k++) begin
         send_item(OP_STORE, frame_buf[k], 1'b0);
         if ($urandom_range(0, 11) == 0) send_item(OP_POLL, 8'($urandom), 1'b0);
      end
      repeat ($urandom_range(1, 3)) send_item(OP_POLL, 8'($urandom), 1'b0);
   endtask

   task automatic random_phase(int count);
      int stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         burst = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(5, 20)) send_item(OP_STORE, 8'($urandom), 1'b0);
            send_item(OP_POLL, 8'($urandom), 1'b0);
         end else if ($urandom_range(0, 15) == 0) begin
            // Overfill the ring so that the write offset can lap the read offset.
            repeat ($urandom_range(120, 140)) send_item(OP_STORE, 8'($urandom), 1'b0);
            send_item(OP_POLL, 8'($urandom), 1'b0);
         end else begin
            send_frame_run();
         end
      end
      burst = 1'b0;
   endtask

   function automatic void check_field(string name, int expd, int act);
      if (expd != act) begin
         errors++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, expd, act);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type expd;
      if (!reset && rsp_strobe) begin
         if (frame_out_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected item, expected none, actual %p", $time, rsp_data);
         end else begin
            expd = frame_out_q.pop_front();
            check_field("status", expd.status, rsp_data.status);
            check_field("frame_byte", expd.frame_byte, rsp_data.frame_byte);
            check_field("last_byte", expd.last_byte, rsp_data.last_byte);
            check_field("command", expd.command, rsp_data.command);
            check_field("frame_length", expd.frame_length, rsp_data.frame_length);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_strobe || (req_start && !req_busy) || (csr_psel && csr_penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      rd_ofs = 0;
      wr_ofs = 0;
      hdr_seen = 1'b0;
      pend_len = 0;
      sync_copy = SYNC_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) send_item(directed[i].op, directed[i].data, directed[i].no_frame_typed);
      random_phase(45);
      wait_quiet();
      write_sync(32'h0000_0000);
      random_phase(45);
      wait_quiet();
      write_sync(32'hFFFF_FFFF);
      random_phase(45);
      wait_quiet();
      write_sync($urandom);
      random_phase(35);
      wait_quiet();
      write_sync(SYNC_RESET);
      random_phase(20);
      wait_quiet();
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
